// ===== rtl/pwn_pkg.sv =====
`timescale 1ns / 1ps

package pwn_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int COORD_WIDTH_DEF  = 24;

    localparam int EC_W   = 11;
    localparam int IDX_W  = 10;
    localparam int WN_W   = 12;

    localparam logic [EC_W-1:0] EC_RESET = EC_W'(3);

    typedef enum logic [0:0] {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req_type;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LATCH,
        S_MUL1,
        S_MUL2,
        S_ACC,
        S_DONE
    } t_state;

endpackage

// ===== rtl/polygon_winding_number_test.sv =====
`timescale 1ns / 1ps

// Load item: written straight into the vertex RAM when taken, if its index is in range.
// Query item: per edge a RAM read, a latch, two passes through the shared multiplier and
// an accumulate; vertex 0 is read once and reused by the closing edge, edge_count being capped
// at MAX_VERTICES; a query with zero edges posts with no edge work. Input stalls until the post,
// which an unread older result holds off.
// Sync active-low reset clears the sequencer and output valid, sets edge_count to 3, not RAM.
module polygon_winding_number_test #(
    parameter int MAX_VERTICES = pwn_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = pwn_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pwn_pkg::t_req_type            i_req_type,
    input  logic [pwn_pkg::IDX_W-1:0]     i_vertex_index,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [pwn_pkg::WN_W-1:0] o_winding_number,
    output logic                          o_inside_res,
    // edge_count register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pwn_pkg::EC_W-1:0]      i_cfg_data
);

    import pwn_pkg::*;

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int CW  = COORD_WIDTH;
    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * DW;
    localparam int WNW = $clog2(MAX_VERTICES) + 2;
    localparam logic [31:0] MAXV32 = 32'(MAX_VERTICES);

    t_state r_state, n_state;

    logic [EC_W-1:0]       r_ec, n_ec;
    logic                  r_out_valid, n_out_valid;
    logic [AW-1:0]         r_i, n_i;
    logic [AW-1:0]         r_last, n_last;
    logic                  r_first, n_first;
    logic signed [WNW-1:0] r_wn, n_wn;

    logic signed [CW-1:0] r_px, r_py;
    logic signed [CW-1:0] r_prev_x, r_prev_y;
    logic signed [CW-1:0] r_cur_x, r_cur_y;
    logic signed [CW-1:0] r_v0_x, r_v0_y;
    logic signed [PW-1:0] r_p1, r_p2;
    logic signed [WN_W-1:0] r_wn_out;
    logic                 r_inside;

    logic                 in_acc, out_acc;
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [2*CW-1:0]      ram_wdata, ram_rdata;
    logic signed [CW-1:0] rd_x, rd_y;
    logic [31:0]          ec32, n32;
    logic                 load_in_range;
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] product;
    logic                 up_hit, down_hit;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_winding_number = r_wn_out;
    assign o_inside_res     = r_inside;

    // edge count, saturated to the store depth
    assign ec32 = 32'(r_ec);
    assign n32  = (ec32 > MAXV32) ? MAXV32 : ec32;

    assign load_in_range = (32'(i_vertex_index) < MAXV32);

    assign ram_we    = in_acc && (i_req_type == REQ_LOAD) && load_in_range;
    assign ram_waddr = AW'(32'(i_vertex_index));
    assign ram_wdata = {i_coord_y, i_coord_x};
    assign ram_re    = (r_state == S_READ);
    assign ram_raddr = r_first ? '0 : r_i + AW'(1);

    pwn_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_x = signed'(ram_rdata[CW-1:0]);
    assign rd_y = signed'(ram_rdata[2*CW-1:CW]);

    // shared multiplier: first (x1-x0)*(py-y0), then (px-x0)*(y1-y0)
    always_comb begin
        if (r_state == S_MUL1) begin
            mul_a = DW'(r_cur_x) - DW'(r_prev_x);
            mul_b = DW'(r_py) - DW'(r_prev_y);
        end else begin
            mul_a = DW'(r_px) - DW'(r_prev_x);
            mul_b = DW'(r_cur_y) - DW'(r_prev_y);
        end
    end

    assign product = PW'(mul_a) * PW'(mul_b);

    // upward crossing with point left, downward crossing with point right
    assign up_hit   = (r_prev_y <= r_py) && (r_cur_y > r_py) && (r_p1 > r_p2);
    assign down_hit = (r_prev_y > r_py) && (r_cur_y <= r_py) && (r_p1 < r_p2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ec        <= EC_RESET;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_last      <= '0;
            r_first     <= 1'b0;
            r_wn        <= '0;
        end else begin
            r_state     <= n_state;
            r_ec        <= n_ec;
            r_out_valid <= n_out_valid;
            r_i         <= n_i;
            r_last      <= n_last;
            r_first     <= n_first;
            r_wn        <= n_wn;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ec        = r_ec;
        n_out_valid = r_out_valid;
        n_i         = r_i;
        n_last      = r_last;
        n_first     = r_first;
        n_wn        = r_wn;

        if (i_cfg_valid && o_cfg_ready) begin
            n_ec = i_cfg_data;
        end
        if (out_acc) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_req_type == REQ_QUERY)) begin
                    n_i     = '0;
                    n_first = 1'b1;
                    n_wn    = '0;
                    n_last  = AW'(n32 - 32'd1);
                    n_state = (r_ec == '0) ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                n_state = S_LATCH;
            end
            S_LATCH: begin
                n_first = 1'b0;
                // a single edge closes vertex 0 onto itself
                if (r_first && (r_last != '0)) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                if (up_hit) begin
                    n_wn = r_wn + WNW'(1);
                end else if (down_hit) begin
                    n_wn = r_wn - WNW'(1);
                end
                if (r_i == r_last) begin
                    n_state = S_DONE;
                end else begin
                    n_i = r_i + AW'(1);
                    // closing edge reuses the held vertex 0
                    n_state = (r_i + AW'(1) == r_last) ? S_MUL1 : S_READ;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_px <= i_coord_x;
                    r_py <= i_coord_y;
                end
            end
            S_LATCH: begin
                if (r_first) begin
                    r_prev_x <= rd_x;
                    r_prev_y <= rd_y;
                    r_v0_x   <= rd_x;
                    r_v0_y   <= rd_y;
                end
                r_cur_x <= rd_x;
                r_cur_y <= rd_y;
            end
            S_MUL1: begin
                r_p1 <= product;
            end
            S_MUL2: begin
                r_p2 <= product;
            end
            S_ACC: begin
                r_prev_x <= r_cur_x;
                r_prev_y <= r_cur_y;
                r_cur_x  <= r_v0_x;
                r_cur_y  <= r_v0_y;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    r_wn_out <= WN_W'(r_wn);
                    r_inside <= (r_wn != '0);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/pwn_ram.sv =====
`timescale 1ns / 1ps

module pwn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/polygon_winding_number_test_test.sv =====
`timescale 1ns / 1ps

module polygon_winding_number_test_test;
    import pwn_pkg::*;

    localparam int MAX_V        = MAX_VERTICES_DEF;
    localparam int COORD_W      = COORD_WIDTH_DEF;
    localparam int FULL_SPAN    = (1 << (COORD_W - 1)) - 1;
    localparam int RANDOM_ITEMS = 380;
    localparam int FILL_V       = 160;
    localparam int SETTLE       = 16;
    localparam int DRAIN_CYCLES = 5 * MAX_V + 16;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        t_req_type                  kind;
        logic [IDX_W-1:0]           slot;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } t_poly_req;

    typedef struct packed {
        logic signed [WN_W-1:0] wn;
        logic                   in_poly;
    } t_tally;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       in_valid = 1'b0;
    logic                       o_in_stall;
    t_req_type                  in_req = REQ_LOAD;
    logic [IDX_W-1:0]           in_slot = '0;
    logic signed [COORD_W-1:0]  in_x = '0;
    logic signed [COORD_W-1:0]  in_y = '0;

    logic                       o_out_valid;
    logic                       out_stall = 1'b0;
    logic signed [WN_W-1:0]     o_winding_number;
    logic                       o_inside_res;

    logic                       cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [EC_W-1:0]            cfg_data = '0;

    t_poly_req  req_queue[$];
    t_tally     expected_windings[$];
    t_poly_req  cur_req;

    // predictor state
    longint          shadow_x[MAX_V];
    longint          shadow_y[MAX_V];
    logic [EC_W-1:0] edges_in_use = EC_RESET;

    // stimulus-side copy of the polygon being built
    int gen_x[MAX_V];
    int gen_y[MAX_V];

    int  send_wait = 0;
    int  recv_wait = 0;
    bit  sender_calm = 1'b0;
    bit  receiver_calm = 1'b0;
    int  mismatches = 0;
    int  random_items = 0;
    int  cycle_count = 0;

    polygon_winding_number_test dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (in_req),
        .i_vertex_index   (in_slot),
        .i_coord_x        (in_x),
        .i_coord_y        (in_y),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_winding_number (o_winding_number),
        .o_inside_res     (o_inside_res),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int draw_wait(input bit calm);
        if (calm || $urandom_range(0, 1))
            return 0;
        return $urandom_range(0, 11);
    endfunction

    // Signed crossing count of the stored polygon around (px, py).
    function automatic int winding_of(input longint px, input longint py);
        int     wn;
        int     n;
        int     i;
        int     j;
        longint x0, y0, x1, y1, cr;
        wn = 0;
        n = (int'(edges_in_use) > MAX_V) ? MAX_V : int'(edges_in_use);
        for (i = 0; i < n; i++) begin
            j = (i + 1 == n) ? 0 : i + 1;
            x0 = shadow_x[i];
            y0 = shadow_y[i];
            x1 = shadow_x[j];
            y1 = shadow_y[j];
            cr = (x1 - x0) * (py - y0) - (px - x0) * (y1 - y0);
            if (y0 <= py) begin
                if (y1 > py && cr > 0)
                    wn++;
            end else begin
                if (y1 <= py && cr < 0)
                    wn--;
            end
        end
        return wn;
    endfunction

    task automatic absorb_request(input t_poly_req r);
        t_tally t;
        int     wn;
        if (r.kind == REQ_LOAD) begin
            shadow_x[r.slot] = r.x;
            shadow_y[r.slot] = r.y;
        end else begin
            wn = winding_of(r.x, r.y);
            t.wn = wn[WN_W-1:0];
            t.in_poly = (wn != 0);
            expected_windings.push_back(t);
        end
    endtask

    // Driver: present queued items, taking each on a handshake.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_wait = 0;
            edges_in_use = EC_RESET;
        end else begin
            if (cfg_valid && o_cfg_ready)
                edges_in_use = cfg_data;
            if (in_valid && !o_in_stall)
                absorb_request(cur_req);
            if (!in_valid || !o_in_stall) begin
                if (send_wait > 0) begin
                    send_wait = send_wait - 1;
                    in_valid <= 1'b0;
                end else if (req_queue.size() > 0) begin
                    cur_req = req_queue.pop_front();
                    in_req <= cur_req.kind;
                    in_slot <= cur_req.slot;
                    in_x <= cur_req.x;
                    in_y <= cur_req.y;
                    in_valid <= 1'b1;
                    send_wait = draw_wait(sender_calm);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report(input string what, input t_tally want, input t_tally got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: winding expected %0d got %0d, inside expected %0b got %0b",
                     what, want.wn, got.wn, want.in_poly, got.in_poly);
    endtask

    // Monitor: take results and compare against the oldest expectation.
    always @(posedge i_clk) begin
        t_tally got;
        t_tally want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            recv_wait = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                got.wn = o_winding_number;
                got.in_poly = o_inside_res;
                if (expected_windings.size() == 0) begin
                    want = '0;
                    report("unexpected result", want, got);
                end else begin
                    want = expected_windings.pop_front();
                    if (got.wn !== want.wn || got.in_poly !== want.in_poly)
                        report("mismatch", want, got);
                end
                recv_wait = draw_wait(receiver_calm);
            end else if (recv_wait > 0) begin
                recv_wait = recv_wait - 1;
            end
            out_stall <= (recv_wait > 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int rand_in(input int center, input int span);
        return center - span + int'($urandom_range(0, 2 * span));
    endfunction

    function automatic int raw_coord();
        return $signed($urandom()) >>> (32 - COORD_W);
    endfunction

    // style 1 walks the corners of a square, so the polygon loops around its center
    function automatic void shape_vertex(input int style, input int k, input int h,
                                         input int cx, input int cy, input bit ccw,
                                         output int vx, output int vy);
        int corner;
        int sx;
        int sy;
        if (style == 1) begin
            corner = k % 4;
            sx = (corner == 1 || corner == 2) ? 1 : -1;
            sy = (corner >= 2) ? 1 : -1;
            if (!ccw)
                sx = -sx;
            vx = cx + sx * h + rand_in(0, h / 8);
            vy = cy + sy * h + rand_in(0, h / 8);
        end else begin
            vx = rand_in(cx, h);
            vy = rand_in(cy, h);
        end
    endfunction

    task automatic push_load(input int slot, input int x, input int y);
        t_poly_req r;
        r.kind = REQ_LOAD;
        r.slot = slot[IDX_W-1:0];
        r.x = x[COORD_W-1:0];
        r.y = y[COORD_W-1:0];
        req_queue.push_back(r);
        gen_x[slot] = x;
        gen_y[slot] = y;
    endtask

    task automatic push_query(input int x, input int y);
        t_poly_req r;
        r.kind = REQ_QUERY;
        r.slot = $urandom_range(0, MAX_V - 1);
        r.x = x[COORD_W-1:0];
        r.y = y[COORD_W-1:0];
        req_queue.push_back(r);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (req_queue.size() != 0 || in_valid || expected_windings.size() != 0);
    endtask

    task automatic set_edge_count(input int n);
        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= n[EC_W-1:0];
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase();
        int n, style, cnt, pick, k, h, qh, cx, cy, vx, vy, i;
        bit ccw;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            n = $urandom_range(0, 2);
        else if (pick == 1)
            n = $urandom_range(13, 40);
        else
            n = $urandom_range(3, 12);
        style = $urandom_range(0, 2);
        h = (style == 2) ? FULL_SPAN : $urandom_range(16, 65536);
        qh = (style == 2) ? h : h + h / 4;
        cx = (style == 2) ? 0 : rand_in(0, FULL_SPAN - 2 * h);
        cy = (style == 2) ? 0 : rand_in(0, FULL_SPAN - 2 * h);
        ccw = $urandom_range(0, 1);
        set_edge_count(n);
        sender_calm = ($urandom_range(0, 3) == 0);
        receiver_calm = ($urandom_range(0, 3) == 0);
        for (k = 0; k < n; k++) begin
            shape_vertex(style, k, h, cx, cy, ccw, vx, vy);
            push_load(k, vx, vy);
        end
        cnt = $urandom_range(8, 24);
        for (i = 0; i < cnt; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                pick = $urandom_range(0, 3);
                if (pick <= 1 || n == 0) begin
                    push_query(rand_in(cx, qh), rand_in(cy, qh));
                end else if (pick == 2) begin
                    // sit exactly on a vertex's y to hit the crossing boundaries
                    k = $urandom_range(0, n - 1);
                    push_query(rand_in(cx, qh), gen_y[k]);
                end else if ($urandom_range(0, 1)) begin
                    k = $urandom_range(0, n - 1);
                    push_query(gen_x[k], gen_y[k]);
                end else begin
                    push_query(raw_coord(), raw_coord());
                end
            end else if (pick == 7 && n > 0) begin
                k = $urandom_range(0, n - 1);
                shape_vertex(style, k, h, cx, cy, ccw, vx, vy);
                push_load(k, vx, vy);
            end else begin
                push_load($urandom_range(0, MAX_V - 1), raw_coord(), raw_coord());
            end
        end
        random_items += n + cnt;
    endtask

    initial begin
        int k, h, cx, cy, vx, vy;
        bit ccw;
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // triangle at the coordinate extremes, counterclockwise, reset edge count
        push_load(0, -8388608, -8388608);
        push_load(1, 8388607, -8388608);
        push_load(2, 0, 8388607);
        push_query(0, 0);
        push_query(8388607, 8388607);
        push_query(-8388608, -8388608);
        push_query(0, -8388608);
        push_query(0, 8388607);
        push_query(-8388608, 0);
        // same triangle clockwise
        push_load(1, 0, 8388607);
        push_load(2, 8388607, -8388608);
        push_query(0, 0);
        push_query(100, -8388608);

        // no edges, a single closing edge, a back-and-forth pair
        set_edge_count(0);
        push_query(0, 0);
        set_edge_count(1);
        push_query(0, 0);
        push_query(-8388608, -8388608);
        set_edge_count(2);
        push_query(0, 0);
        push_query(-8388609 + 2, 0);

        while (random_items < RANDOM_ITEMS)
            random_phase();

        // a long polygon: a square walked many times over
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
        h = 4096;
        cx = rand_in(0, 1 << 20);
        cy = rand_in(0, 1 << 20);
        ccw = $urandom_range(0, 1);
        for (k = 0; k < FILL_V; k++) begin
            shape_vertex(1, k, h, cx, cy, ccw, vx, vy);
            push_load(k, vx, vy);
        end
        set_edge_count(FILL_V);
        push_query(cx, cy);
        push_query(rand_in(cx, h), rand_in(cy, h));
        push_query(rand_in(cx, h), gen_y[$urandom_range(0, FILL_V - 1)]);
        push_query(raw_coord(), raw_coord());
        // stop partway round the last lap so the closing edge cuts across
        set_edge_count(FILL_V - 3);
        push_query(cx, cy);
        push_query(rand_in(cx, h + h / 4), rand_in(cy, h + h / 4));

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_windings.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
